[sv/moving_average_nan_aware_assert.svh]
// assertion macros shared by the moving average block
`ifndef MOVING_AVERAGE_NAN_AWARE_ASSERT_SVH
`define MOVING_AVERAGE_NAN_AWARE_ASSERT_SVH

// condition holds at every edge out of reset
`define MAVG_ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error(msg);

// consequent holds in the same cycle as the antecedent
`define MAVG_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define MAVG_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/mavg_pkg.sv]
package mavg_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int CFG_DATA_W = 7;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DROP_INVALID    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INVALID_AS_ZERO = 2'd2;

    localparam logic [CFG_DATA_W-1:0] WINDOW_LENGTH_RESET = 7'd16;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       sample_invalid;
    } in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] average;
        logic                       average_valid;
    } out_t;

    // one window entry: replaced mark, raw not-a-number mark, value
    typedef struct packed {
        logic                repl;
        logic                raw;
        logic [SAMPLE_W-1:0] value;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

[sv/mavg_ram.sv]
module mavg_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 34
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/mavg_div.sv]
module mavg_div #(
    parameter int DVD_W = 38,
    parameter int DVS_W = 7
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int CNT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DVS_W:0]   trial;
    logic             fits;

    // restoring division, one quotient bit per cycle, msb first
    assign trial = {rem_reg, quo_reg[DVD_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = CNT_W'(DVD_W - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? DVS_W'(trial - {1'b0, dvs_reg}) : trial[DVS_W-1:0];
            quo_next = {quo_reg[DVD_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        cnt_reg <= cnt_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[sv/moving_average_nan_aware.sv]
// Moving average over the last window_length Q16.16 samples, with three ways
// to treat samples flagged not-a-number: drop them, enter them as zero and
// leave them out of the divisor, or keep them raw and mark the average invalid.
// Input requests come in on s_valid/s_ready/s_data, one result per request goes
// out on m_valid/m_ready/m_data. The cfg_wr_en/cfg_index/cfg_wdata port writes
// window_length (0), drop_invalid (1) and invalid_as_zero (2); writing
// window_length empties the window. Write it only while the block is idle.
// The window entries sit in a one-port-write, one-port-read RAM: the oldest
// entry is read when a request is taken, the sum and counts are updated and
// the new entry written in the next cycle.
// Steps: a taken request passes through ST_UPDATE (skipped when it is
// dropped) and ST_CHECK; a valid average then goes through ST_DIV, where the
// radix-2 divider retires one quotient bit of the SUM_W-bit sum per cycle,
// while an invalid average goes straight to ST_OUT. The next request is taken
// in the cycle after the result moves to the output register, so requests
// are handled one at a time.
// Reset empties the window, sets window_length to 16 and both modes to off;
// the RAM needs no clearing since only entries inside the window are read.
// While m_ready is low a finished result waits in the output register and
// the next result, once done, waits in its holding register.
`include "moving_average_nan_aware_assert.svh"

module moving_average_nan_aware #(
    parameter int WINDOW_MAX = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  mavg_pkg::in_t                       s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output mavg_pkg::out_t                      m_data,
    input  logic                                cfg_wr_en,
    input  logic [mavg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mavg_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    import mavg_pkg::*;

    localparam int SLOT_W = $clog2(WINDOW_MAX);
    localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW_MAX);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_UPDATE = 3'd1;
    localparam logic [2:0] ST_CHECK  = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_OUT    = 3'd4;

    logic [2:0]              state_reg, state_next;
    logic [CFG_DATA_W-1:0]   wl_reg, wl_next;
    logic                    drop_reg, drop_next;
    logic                    iaz_reg, iaz_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0]        fill_reg, fill_next;
    logic [SLOT_W-1:0]       oldest_reg, oldest_next;
    logic [CNT_W-1:0]        repl_reg, repl_next;
    logic [CNT_W-1:0]        raw_reg, raw_next;
    logic                    m_valid_reg, m_valid_next;
    entry_t                  entry_reg, entry_next;
    logic                    evict_reg, evict_next;
    logic                    neg_reg, neg_next;
    out_t                    result_reg, result_next;
    out_t                    m_data_reg, m_data_next;

    logic                    s_accept;
    logic [CNT_W-1:0]        len_c;
    logic                    evict_c;
    entry_t                  old_entry;
    logic [ENTRY_W-1:0]      ram_rdata;
    logic signed [SUM_W-1:0] old_val;
    logic signed [SUM_W-1:0] new_val;
    logic signed [SUM_W-1:0] sum_upd;
    logic [SLOT_W-1:0]       oldest_inc;
    logic [SLOT_W-1:0]       oldest_upd;
    logic [CNT_W-1:0]        fill_less;
    logic [CNT_W:0]          slot_sum;
    logic [CNT_W:0]          slot_wrap;
    logic [SLOT_W-1:0]       waddr;
    logic                    ram_we;
    logic [CNT_W-1:0]        divisor_c;
    logic                    ok_c;
    logic [SUM_W-1:0]        sum_mag;
    logic                    div_start;
    logic                    div_done;
    logic [SUM_W-1:0]        quo;
    logic [SUM_W:0]          q_signed;
    logic [SUM_W:SAMPLE_W-1] q_hi;
    logic [SAMPLE_W-1:0]     avg_sat;
    logic [CNT_W:0]          marks_c;

    assign s_ready  = state_reg == ST_IDLE;
    assign s_accept = s_valid && s_ready;

    // zero acts as one, anything above the store depth as the depth
    assign len_c = (wl_reg == '0) ? CNT_W'(1) :
                   ((32'(wl_reg) > WINDOW_MAX) ? CNT_W'(WINDOW_MAX) : CNT_W'(wl_reg));
    assign evict_c = fill_reg == len_c;

    assign old_entry = entry_t'(ram_rdata);
    assign old_val   = evict_reg ?
        {{(SUM_W-SAMPLE_W){old_entry.value[SAMPLE_W-1]}}, old_entry.value} : '0;
    assign new_val   = {{(SUM_W-SAMPLE_W){entry_reg.value[SAMPLE_W-1]}}, entry_reg.value};
    assign sum_upd   = sum_reg - old_val + new_val;

    assign oldest_inc = (oldest_reg == SLOT_W'(WINDOW_MAX - 1)) ? '0 : oldest_reg + 1'b1;
    assign oldest_upd = evict_reg ? oldest_inc : oldest_reg;
    assign fill_less  = fill_reg - CNT_W'(evict_reg);
    assign slot_sum   = (CNT_W+1)'(oldest_upd) + (CNT_W+1)'(fill_less);
    assign slot_wrap  = (slot_sum >= (CNT_W+1)'(WINDOW_MAX)) ?
                        slot_sum - (CNT_W+1)'(WINDOW_MAX) : slot_sum;
    assign waddr      = slot_wrap[SLOT_W-1:0];
    assign ram_we     = state_reg == ST_UPDATE;

    mavg_ram #(
        .DEPTH (WINDOW_MAX),
        .WIDTH (ENTRY_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (entry_reg),
        .raddr (oldest_reg),
        .rdata (ram_rdata)
    );

    assign divisor_c = len_c - (iaz_reg ? repl_reg : '0);
    assign ok_c      = (fill_reg == len_c) && (divisor_c != '0) && (raw_reg == '0);
    assign sum_mag   = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign div_start = (state_reg == ST_CHECK) && ok_c;

    mavg_div #(
        .DVD_W (SUM_W),
        .DVS_W (CNT_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_mag),
        .divisor  (divisor_c),
        .done     (div_done),
        .quotient (quo)
    );

    // truncation toward zero: divide magnitudes, then restore the sign
    assign q_signed = neg_reg ? -{1'b0, quo} : {1'b0, quo};
    assign q_hi     = q_signed[SUM_W:SAMPLE_W-1];
    assign avg_sat  = ((&q_hi) || !(|q_hi)) ? q_signed[SAMPLE_W-1:0] :
                      (q_signed[SUM_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                                       : {1'b0, {(SAMPLE_W-1){1'b1}}});

    always_comb begin
        state_next   = state_reg;
        wl_next      = wl_reg;
        drop_next    = drop_reg;
        iaz_next     = iaz_reg;
        sum_next     = sum_reg;
        fill_next    = fill_reg;
        oldest_next  = oldest_reg;
        repl_next    = repl_reg;
        raw_next     = raw_reg;
        entry_next   = entry_reg;
        evict_next   = evict_reg;
        neg_next     = neg_reg;
        result_next  = result_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (s_data.sample_invalid) begin
                        entry_next.repl  = iaz_reg;
                        entry_next.raw   = !iaz_reg;
                        entry_next.value = '0;
                    end else begin
                        entry_next.repl  = 1'b0;
                        entry_next.raw   = 1'b0;
                        entry_next.value = s_data.sample;
                    end
                    evict_next = evict_c;
                    // a dropped request leaves the window untouched
                    state_next = (s_data.sample_invalid && drop_reg) ? ST_CHECK : ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                sum_next    = sum_upd;
                oldest_next = oldest_upd;
                fill_next   = fill_less + 1'b1;
                repl_next   = repl_reg - CNT_W'(evict_reg && old_entry.repl)
                            + CNT_W'(entry_reg.repl);
                raw_next    = raw_reg - CNT_W'(evict_reg && old_entry.raw)
                            + CNT_W'(entry_reg.raw);
                state_next  = ST_CHECK;
            end
            ST_CHECK: begin
                neg_next = sum_reg[SUM_W-1];
                if (ok_c) begin
                    state_next = ST_DIV;
                end else begin
                    result_next = '0;
                    state_next  = ST_OUT;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    result_next.average       = avg_sat;
                    result_next.average_valid = 1'b1;
                    state_next                = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next  = result_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_WINDOW_LENGTH: begin
                    wl_next     = cfg_wdata;
                    sum_next    = '0;
                    fill_next   = '0;
                    oldest_next = '0;
                    repl_next   = '0;
                    raw_next    = '0;
                end
                CFG_DROP_INVALID: begin
                    drop_next = cfg_wdata[0];
                end
                CFG_INVALID_AS_ZERO: begin
                    iaz_next = cfg_wdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            wl_reg      <= WINDOW_LENGTH_RESET;
            drop_reg    <= 1'b0;
            iaz_reg     <= 1'b0;
            sum_reg     <= '0;
            fill_reg    <= '0;
            oldest_reg  <= '0;
            repl_reg    <= '0;
            raw_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wl_reg      <= wl_next;
            drop_reg    <= drop_next;
            iaz_reg     <= iaz_next;
            sum_reg     <= sum_next;
            fill_reg    <= fill_next;
            oldest_reg  <= oldest_next;
            repl_reg    <= repl_next;
            raw_reg     <= raw_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg  <= entry_next;
        evict_reg  <= evict_next;
        neg_reg    <= neg_next;
        result_reg <= result_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign marks_c = (CNT_W+1)'(repl_reg) + (CNT_W+1)'(raw_reg);

    `MAVG_ASSERT_ALWAYS(a_fill_bound, aclk, aresetn, fill_reg <= len_c,
        "window fill beyond effective length")
    `MAVG_ASSERT_ALWAYS(a_mark_bound, aclk, aresetn, marks_c <= (CNT_W+1)'(fill_reg),
        "marked entries exceed window fill")
    `MAVG_ASSERT_IMPLY(a_div_done, aclk, aresetn, div_done, state_reg == ST_DIV,
        "divider finished outside the divide state")
    `MAVG_ASSERT_NEXT(a_accept_step, aclk, aresetn, s_accept,
        state_reg == ST_UPDATE || state_reg == ST_CHECK,
        "accepted request did not start processing")

endmodule

[test/moving_average_nan_aware_tb.sv]
module moving_average_nan_aware_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mavg_pkg::*;

    localparam int WINDOW_MAX      = 64;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 8;
    localparam int CYCLE_LIMIT     = 200000;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 32'h7FFF_FFFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 32'h8000_0000;
    localparam logic signed [SAMPLE_W-1:0] ONE_Q16    = 32'h0001_0000;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_t                   s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_t                  m_data;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    // shadow copy of the window and registers
    entry_t                win_ring [WINDOW_MAX];
    longint                win_sum;
    int unsigned           win_fill;
    int unsigned           win_head;
    int unsigned           repl_in_window;
    int unsigned           raw_in_window;
    logic [CFG_DATA_W-1:0] length_reg;
    logic                  drop_reg;
    logic                  zero_reg;

    out_t expected_averages [$];
    int   error_count;
    int   cycle_count;
    bit   idle_on;
    bit   hold_off_pending;

    moving_average_nan_aware #(
        .WINDOW_MAX(WINDOW_MAX)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    function automatic void flush_window();
        win_sum        = 0;
        win_fill       = 0;
        win_head       = 0;
        repl_in_window = 0;
        raw_in_window  = 0;
    endfunction

    function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
                                           logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_WINDOW_LENGTH: begin
                length_reg = val;
                flush_window();
            end
            CFG_DROP_INVALID: begin
                drop_reg = val[0];
            end
            CFG_INVALID_AS_ZERO: begin
                zero_reg = val[0];
            end
            default: begin
            end
        endcase
    endfunction

    // advances the shadow window by one request and returns the average it gives
    function automatic out_t step_window_average(in_t req);
        int unsigned               len;
        entry_t                    fresh;
        entry_t                    old;
        logic signed [SAMPLE_W-1:0] v;
        longint                    divisor;
        longint                    q;
        out_t                      res;
        len = length_reg;
        if (len < 1) len = 1;
        if (len > WINDOW_MAX) len = WINDOW_MAX;
        if (!(req.sample_invalid && drop_reg)) begin
            fresh = '0;
            if (req.sample_invalid) begin
                fresh.repl = zero_reg;
                fresh.raw  = !zero_reg;
            end else begin
                fresh.value = req.sample;
            end
            if (win_fill >= len) begin
                old = win_ring[win_head];
                v = old.value;
                win_sum -= v;
                if (old.repl && repl_in_window > 0) repl_in_window--;
                if (old.raw && raw_in_window > 0) raw_in_window--;
                win_head = (win_head + 1) % WINDOW_MAX;
                win_fill--;
            end
            win_ring[(win_head + win_fill) % WINDOW_MAX] = fresh;
            v = fresh.value;
            win_sum += v;
            if (fresh.repl) repl_in_window++;
            if (fresh.raw) raw_in_window++;
            win_fill++;
        end
        divisor = len;
        if (zero_reg) divisor -= repl_in_window;
        res = '0;
        if (win_fill == len && divisor > 0 && raw_in_window == 0) begin
            q = win_sum / divisor;
            if (q > 64'sd2147483647) q = 64'sd2147483647;
            if (q < -64'sd2147483648) q = -64'sd2147483648;
            res.average       = q[SAMPLE_W-1:0];
            res.average_valid = 1'b1;
        end
        return res;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return int'($urandom_range(0, 131072000)) - 65536000;
            2: begin
                case ($urandom_range(0, 3))
                    0: return SAMPLE_MAX;
                    1: return SAMPLE_MIN;
                    2: return '0;
                    default: return -1;
                endcase
            end
            default: return int'($urandom_range(0, 200)) - 100;
        endcase
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] value, input logic nan);
        in_t req;
        int  gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        req.sample         = value;
        req.sample_invalid = nan;
        s_data  <= req;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        expected_averages.push_back(step_window_average(req));
        @(negedge aclk);
    endtask

    task automatic drain_pipeline();
        s_valid <= 1'b0;
        while (expected_averages.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        apply_register(idx, val);
        @(negedge aclk);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] len, input logic drop,
                             input logic zero);
        drain_pipeline();
        write_reg(CFG_DROP_INVALID, CFG_DATA_W'(drop));
        write_reg(CFG_INVALID_AS_ZERO, CFG_DATA_W'(zero));
        write_reg(CFG_WINDOW_LENGTH, len);
    endtask

    // dropped samples do not count toward the number of requests
    task automatic run_random_requests(input int count, input int nan_pct);
        int  taken;
        logic nan;
        taken = 0;
        while (taken < count) begin
            nan = ($urandom_range(0, 99) < nan_pct);
            send_sample(random_sample(), nan);
            if (!(nan && drop_reg)) taken++;
        end
    endtask

    task automatic test_extremes();
        configure(7'd2, 1'b0, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(-1, 1'b0);
        // -3 / 2 truncates toward zero
        send_sample(-2, 1'b0);
    endtask

    task automatic test_raw_invalid();
        configure(7'd3, 1'b0, 1'b0);
        send_sample(32'hFFFF_FFFF, 1'b1);
        send_sample(ONE_Q16, 1'b0);
        send_sample(2 * ONE_Q16, 1'b0);
        send_sample(3 * ONE_Q16, 1'b0);
    endtask

    task automatic test_invalid_as_zero();
        configure(7'd2, 1'b0, 1'b1);
        send_sample(SAMPLE_MAX, 1'b1);
        // divisor reaches zero here
        send_sample(SAMPLE_MIN, 1'b1);
        send_sample(10 * ONE_Q16, 1'b0);
        // replaced entry leaves after the mode is switched off
        drain_pipeline();
        write_reg(CFG_INVALID_AS_ZERO, '0);
        send_sample(20 * ONE_Q16, 1'b0);
    endtask

    task automatic test_drop_invalid();
        configure(7'd1, 1'b1, 1'b0);
        send_sample(5 * ONE_Q16, 1'b1);
        send_sample(7 * ONE_Q16, 1'b0);
        send_sample(9 * ONE_Q16, 1'b1);
        // drop wins when both modes are on
        drain_pipeline();
        write_reg(CFG_INVALID_AS_ZERO, 7'd1);
        send_sample(11 * ONE_Q16, 1'b1);
    endtask

    task automatic test_length_limits();
        configure(7'd0, 1'b0, 1'b0);
        send_sample(5 * ONE_Q16, 1'b0);
        send_sample(-5 * ONE_Q16, 1'b0);
    endtask

    task automatic test_random_settings();
        configure(7'd5, 1'b0, 1'b0);
        run_random_requests(45, 10);
        // long receiver stall while the window fills
        configure(7'd127, 1'b0, 1'b1);
        hold_off_pending = 1'b1;
        run_random_requests(100, 5);
        configure(7'd0, 1'b1, 1'b0);
        run_random_requests(30, 30);
        configure(7'd3, 1'b0, 1'b1);
        run_random_requests(40, 30);
        configure(7'd7, 1'b1, 1'b1);
        run_random_requests(40, 25);
        configure(7'd64, 1'b0, 1'b0);
        run_random_requests(70, 1);
        configure(CFG_DATA_W'($urandom_range(1, 20)), 1'($urandom), 1'($urandom));
        run_random_requests(50, 15);
    endtask

    task automatic test_mode_change();
        configure(7'd8, 1'b0, 1'b1);
        run_random_requests(20, 30);
        drain_pipeline();
        write_reg(CFG_INVALID_AS_ZERO, '0);
        run_random_requests(20, 10);
    endtask

    task automatic test_steady_stream();
        configure(7'd2, 1'($urandom), 1'($urandom));
        idle_on = 1'b0;
        run_random_requests(40, 15);
    endtask

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("moving_average_nan_aware test failed");
        $finish;
    end

    initial begin : receiver
        int n;
        m_ready = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off_pending) begin
                hold_off_pending = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                n = $urandom_range(1, 9);
                repeat (n) @(negedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : check_results
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_averages.size() == 0) begin
                $display("%0t: unexpected result average=%0d valid=%0b", $time,
                         m_data.average, m_data.average_valid);
                error_count++;
            end else begin
                want = expected_averages.pop_front();
                if (m_data.average_valid !== want.average_valid) begin
                    $display("%0t: average_valid mismatch expected=%0b actual=%0b", $time,
                             want.average_valid, m_data.average_valid);
                    error_count++;
                end
                if (m_data.average !== want.average) begin
                    $display("%0t: average mismatch expected=%0d actual=%0d", $time,
                             want.average, m_data.average);
                    error_count++;
                end
            end
        end
    end

    initial begin
        error_count      = 0;
        idle_on          = 1'b1;
        hold_off_pending = 1'b0;
        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_data           = '0;
        cfg_wr_en        = 1'b0;
        cfg_index        = '0;
        cfg_wdata        = '0;
        length_reg       = WINDOW_LENGTH_RESET;
        drop_reg         = 1'b0;
        zero_reg         = 1'b0;
        flush_window();
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_extremes();
        test_raw_invalid();
        test_invalid_as_zero();
        test_drop_invalid();
        test_length_limits();
        test_random_settings();
        test_mode_change();
        test_steady_stream();

        drain_pipeline();
        if (error_count == 0) begin
            $display("moving_average_nan_aware test passed");
        end else begin
            $display("moving_average_nan_aware test failed");
        end
        $finish;
    end

endmodule

[moving_average_nan_aware.f]
+incdir+sv
sv/mavg_pkg.sv
sv/mavg_ram.sv
sv/mavg_div.sv
sv/moving_average_nan_aware.sv
test/moving_average_nan_aware_tb.sv
